// ===== src/ssg_pkg.sv =====
package ssg_pkg;

	localparam int CMD_W   = 3;
	localparam int ID_W    = 16;
	localparam int SLOT_W  = 5;
	localparam int DIST_W  = 7;
	localparam int COUNT_W = 6;
	localparam int SCORE_W = 38;
	localparam int DELTA_W = 25;
	localparam int STAT_W  = 2;
	localparam int NCNT_W  = 17;
	localparam int IN_W    = 96;
	localparam int OUT_W   = 72;

	localparam logic [SCORE_W-1:0] SCORE_MAX = {SCORE_W{1'b1}};

	localparam logic [CMD_W-1:0] CMD_SET_SIDE  = 3'd0;
	localparam logic [CMD_W-1:0] CMD_WR_NBR    = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SET_COUNT = 3'd2;
	localparam logic [CMD_W-1:0] CMD_LOAD      = 3'd3;
	localparam logic [CMD_W-1:0] CMD_SWAP      = 3'd4;
	localparam logic [CMD_W-1:0] CMD_READ_SIDE = 3'd5;
	localparam logic [CMD_W-1:0] CMD_RSVD6     = 3'd6;
	localparam logic [CMD_W-1:0] CMD_RSVD7     = 3'd7;

	localparam logic [STAT_W-1:0] ST_OK      = 2'd0;
	localparam logic [STAT_W-1:0] ST_REFUSED = 2'd1;
	localparam logic [STAT_W-1:0] ST_RANGE   = 2'd2;

	localparam logic REG_ITEM_COUNT = 1'b0;
	localparam logic REG_MISSING    = 1'b1;

	typedef enum logic [3:0] {
		S_CLR,
		S_IDLE,
		S_RA,
		S_RB,
		S_CB,
		S_J,
		S_JD,
		S_K,
		S_KD,
		S_SD,
		S_DEC,
		S_FLB,
		S_OUT
	} state_t;

endpackage

// ===== src/ssg_ram.sv =====
module ssg_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== src/split_swap_gain_evaluator.sv =====
// Swap gain evaluator: keeps a side bit, a neighbour count and up to MAX_NBRS neighbour
// slots per item in on-chip memories, plus a 38-bit score. Loads, reads and rejected swaps
// go straight to the output. A swap walks the listed slots of both items; unlisted pairs
// cancel between the two flipped items, so only listed neighbours are visited. Each slot is
// checked against every later slot of the same list (later slot wins) through the single read
// port of the neighbour memory, and the result may wait on m_tready. After reset a clearing
// pass over all MAX_ITEMS entries zeroes side bits and counts before the first transfer is
// taken.
module split_swap_gain_evaluator
	import ssg_pkg::*;
#(
	parameter int MAX_ITEMS = 1024,
	parameter int MAX_NBRS  = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	// command, item_a, item_b, slot, distance, side, count, score_value
	input  logic [IN_W-1:0]    s_tdata,
	output logic               m_tvalid,
	input  logic               m_tready,
	// status, accepted, score_out, delta_out, side_out
	output logic [OUT_W-1:0]   m_tdata,
	input  logic               cfg_we,
	input  logic               cfg_addr,
	input  logic [NCNT_W-1:0]  cfg_wdata
);

	localparam int IW = $clog2(MAX_ITEMS);
	localparam int SW = (MAX_NBRS > 1) ? $clog2(MAX_NBRS) : 1;
	localparam int CW = $clog2(MAX_NBRS + 1);
	localparam int NW = ID_W + DIST_W;
	localparam logic [IW-1:0] CLR_LAST = IW'(MAX_ITEMS - 1);

	state_t state_q, state_d;

	logic [NCNT_W-1:0]  item_count_q;
	logic [DIST_W-1:0]  miss_q;
	logic [NCNT_W-1:0]  n_eff;

	logic [CMD_W-1:0]   cmd_q;
	logic [ID_W-1:0]    a_q, b_q;
	logic [SLOT_W-1:0]  slot_q;
	logic [DIST_W-1:0]  dist_q;
	logic               side_q;
	logic [COUNT_W-1:0] count_q;
	logic [SCORE_W-1:0] sval_q;

	logic               sa_q, sb_q;
	logic [CW-1:0]      cnta_q, cntb_q, cur_cnt;
	logic               fsel_q;
	logic [CW-1:0]      j_q, k_q;
	logic [ID_W-1:0]    idj_q;
	logic [DIST_W-1:0]  dj_q;
	logic signed [DELTA_W-1:0] acc_q;
	logic [SCORE_W-1:0] score_q;
	logic [IW-1:0]      clr_q;

	logic [STAT_W-1:0]  res_stat_q;
	logic               res_acc_q, res_side_q;

	logic               out_valid_q;
	logic [OUT_W-1:0]   out_data_q;

	logic               a_ok, b_ok, idj_ok, dup;
	logic [IW-1:0]      fidx;
	logic [SCORE_W:0]   score_sum;
	logic signed [DIST_W:0] term;
	logic [6:0]         slot_ext;

	// memory ports
	logic               side_we, side_wdata, side_rdata;
	logic [IW-1:0]      side_waddr, side_raddr;
	logic               cnt_we;
	logic [IW-1:0]      cnt_waddr, cnt_raddr;
	logic [CW-1:0]      cnt_wdata, cnt_rdata;
	logic               nbr_we;
	logic [IW+SW-1:0]   nbr_waddr, nbr_raddr;
	logic [NW-1:0]      nbr_wdata, nbr_rdata;

	ssg_ram #(.W(1), .D(MAX_ITEMS)) u_side (
		.clk(clk), .we(side_we), .waddr(side_waddr), .wdata(side_wdata),
		.raddr(side_raddr), .rdata(side_rdata)
	);

	ssg_ram #(.W(CW), .D(MAX_ITEMS)) u_cnt (
		.clk(clk), .we(cnt_we), .waddr(cnt_waddr), .wdata(cnt_wdata),
		.raddr(cnt_raddr), .rdata(cnt_rdata)
	);

	ssg_ram #(.W(NW), .D(MAX_ITEMS * (2 ** SW))) u_nbr (
		.clk(clk), .we(nbr_we), .waddr(nbr_waddr), .wdata(nbr_wdata),
		.raddr(nbr_raddr), .rdata(nbr_rdata)
	);

	assign n_eff    = (item_count_q < NCNT_W'(MAX_ITEMS)) ? item_count_q : NCNT_W'(MAX_ITEMS);
	assign a_ok     = {1'b0, a_q} < n_eff;
	assign b_ok     = {1'b0, b_q} < n_eff;
	assign idj_ok   = ({1'b0, idj_q} < n_eff) && (idj_q != a_q) && (idj_q != b_q);
	assign dup      = nbr_rdata[NW-1:DIST_W] == idj_q;
	assign cur_cnt  = fsel_q ? cntb_q : cnta_q;
	assign fidx     = fsel_q ? b_q[IW-1:0] : a_q[IW-1:0];
	assign score_sum = {1'b0, score_q} + (SCORE_W+1)'(acc_q);
	assign term     = $signed({1'b0, dj_q}) - $signed({1'b0, miss_q});
	assign slot_ext = 7'(slot_q);

	assign s_tready = (state_q == S_IDLE);
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLR:  if (clr_q == CLR_LAST) state_d = S_IDLE;
			S_IDLE: if (s_tvalid) state_d = S_RA;
			S_RA:   state_d = S_RB;
			S_RB: begin
				if (cmd_q == CMD_SWAP && a_ok && b_ok && a_q != b_q && sa_q != side_rdata)
					state_d = S_CB;
				else
					state_d = S_OUT;
			end
			S_CB:   state_d = S_J;
			S_J: begin
				if (j_q == cur_cnt) begin
					if (fsel_q) state_d = S_DEC;
				end else begin
					state_d = S_JD;
				end
			end
			S_JD:   state_d = S_K;
			S_K:    state_d = (k_q == cur_cnt) ? S_SD : S_KD;
			S_KD:   state_d = dup ? S_J : S_K;
			S_SD:   state_d = S_J;
			S_DEC:  state_d = acc_q[DELTA_W-1] ? S_OUT : S_FLB;
			S_FLB:  state_d = S_OUT;
			S_OUT:  if (!out_valid_q || m_tready) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory controls
	always_comb begin
		side_we    = 1'b0;
		side_waddr = a_q[IW-1:0];
		side_wdata = 1'b0;
		side_raddr = a_q[IW-1:0];
		cnt_we     = 1'b0;
		cnt_waddr  = a_q[IW-1:0];
		cnt_wdata  = '0;
		cnt_raddr  = a_q[IW-1:0];
		nbr_we     = 1'b0;
		nbr_waddr  = {a_q[IW-1:0], slot_ext[SW-1:0]};
		nbr_wdata  = {b_q, dist_q};
		nbr_raddr  = {fidx, j_q[SW-1:0]};
		unique case (state_q)
			S_CLR: begin
				side_we   = 1'b1;
				side_waddr = clr_q;
				cnt_we    = 1'b1;
				cnt_waddr = clr_q;
			end
			S_IDLE: side_raddr = s_tdata[IW+2:3];
			S_RA:   side_raddr = b_q[IW-1:0];
			S_RB: begin
				cnt_raddr = b_q[IW-1:0];
				if (a_ok) begin
					case (cmd_q)
						CMD_SET_SIDE: begin
							side_we    = 1'b1;
							side_wdata = side_q;
						end
						CMD_WR_NBR: nbr_we = ({2'b0, slot_q} < 7'(MAX_NBRS));
						CMD_SET_COUNT: begin
							cnt_we    = ({1'b0, count_q} <= 7'(MAX_NBRS));
							cnt_wdata = CW'(count_q);
						end
						default: ;
					endcase
				end
			end
			S_K: begin
				nbr_raddr  = {fidx, k_q[SW-1:0]};
				side_raddr = idj_q[IW-1:0];
			end
			S_DEC: begin
				side_we    = !acc_q[DELTA_W-1];
				side_wdata = !sa_q;
			end
			S_FLB: begin
				side_we    = 1'b1;
				side_waddr = b_q[IW-1:0];
				side_wdata = !sb_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLR;
			clr_q        <= '0;
			item_count_q <= NCNT_W'(1024);
			miss_q       <= DIST_W'(102);
			score_q      <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				if (cfg_addr == REG_ITEM_COUNT) item_count_q <= cfg_wdata;
				else                            miss_q <= cfg_wdata[DIST_W-1:0];
			end
			if (state_q == S_CLR) clr_q <= clr_q + 1'b1;
			if (state_q == S_RB && cmd_q == CMD_LOAD) score_q <= sval_q;
			if (state_q == S_DEC && !acc_q[DELTA_W-1])
				score_q <= score_sum[SCORE_W] ? SCORE_MAX : score_sum[SCORE_W-1:0];
			if (state_q == S_OUT && (!out_valid_q || m_tready))
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				cmd_q   <= s_tdata[2:0];
				a_q     <= s_tdata[18:3];
				b_q     <= s_tdata[34:19];
				slot_q  <= s_tdata[39:35];
				dist_q  <= s_tdata[46:40];
				side_q  <= s_tdata[47];
				count_q <= s_tdata[53:48];
				sval_q  <= s_tdata[91:54];
			end
			S_RA: sa_q <= side_rdata;
			S_RB: begin
				sb_q       <= side_rdata;
				cnta_q     <= cnt_rdata;
				acc_q      <= '0;
				fsel_q     <= 1'b0;
				j_q        <= '0;
				res_acc_q  <= 1'b0;
				res_side_q <= a_ok ? sa_q : 1'b0;
				res_stat_q <= ST_OK;
				case (cmd_q)
					CMD_SET_SIDE: begin
						if (!a_ok) res_stat_q <= ST_RANGE;
						else       res_side_q <= side_q;
					end
					CMD_WR_NBR:
						if (!a_ok || {2'b0, slot_q} >= 7'(MAX_NBRS)) res_stat_q <= ST_RANGE;
					CMD_SET_COUNT:
						if (!a_ok || {1'b0, count_q} > 7'(MAX_NBRS)) res_stat_q <= ST_RANGE;
					CMD_SWAP: begin
						if (!a_ok || !b_ok)
							res_stat_q <= ST_RANGE;
						else if (a_q == b_q || sa_q == side_rdata)
							res_stat_q <= ST_REFUSED;
					end
					CMD_READ_SIDE: if (!a_ok) res_stat_q <= ST_RANGE;
					default: ;
				endcase
			end
			S_CB: cntb_q <= cnt_rdata;
			S_J: begin
				if (j_q == cur_cnt) begin
					fsel_q <= 1'b1;
					j_q    <= '0;
				end else begin
					k_q <= j_q + 1'b1;
				end
			end
			S_JD: begin
				idj_q <= nbr_rdata[NW-1:DIST_W];
				dj_q  <= nbr_rdata[DIST_W-1:0];
			end
			S_KD: begin
				if (dup) j_q <= j_q + 1'b1;
				else     k_q <= k_q + 1'b1;
			end
			S_SD: begin
				// new side of a is old side of b and vice versa
				if (idj_ok) begin
					if (side_rdata == (fsel_q ? sa_q : sb_q)) acc_q <= acc_q - DELTA_W'(term);
					else                                      acc_q <= acc_q + DELTA_W'(term);
				end
				j_q <= j_q + 1'b1;
			end
			S_DEC: begin
				res_acc_q  <= !acc_q[DELTA_W-1];
				res_side_q <= acc_q[DELTA_W-1] ? sa_q : !sa_q;
			end
			S_OUT: begin
				if (!out_valid_q || m_tready) begin
					out_data_q <= {5'b0, res_side_q, acc_q, score_q, res_acc_q, res_stat_q};
				end
			end
			default: ;
		endcase
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[2] |-> m_tdata[1:0] == ST_OK)
		else $error("swap kept with bad status");

	assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1:0] != ST_OK |-> m_tdata[65:41] == '0)
		else $error("delta on failed command");

	assert property (@(posedge clk) disable iff (!arst_n)
		!$stable(score_q) |-> $past(state_q) == S_DEC || $past(state_q) == S_RB)
		else $error("score changed outside load or swap");

	assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_CLR |-> !s_tready)
		else $error("input taken during clearing pass");

endmodule
